// ===== rtl/encoder_position_pid_move_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the position move unit
// Concurrent checks with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef ENCODER_POSITION_PID_MOVE_UNIT_ASSERT_SVH
`define ENCODER_POSITION_PID_MOVE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define EPPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EPPM_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPPM_ASSERT(lbl, clk, rst, prop, msg)
`define EPPM_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/eppm_pkg.sv =====
// ---------------------------------------------------------------------------
// Position move unit package
// Operation, direction and register codes, widths and shared types.
// ---------------------------------------------------------------------------
package eppm_pkg;

   localparam int DIV_NUM_W = 76;
   localparam int DIV_DEN_W = 32;
   localparam int MUL_W     = 32;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_EDGE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   localparam logic [2:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [2:0] CSR_DERIV_GAIN = 3'd1;
   localparam logic [2:0] CSR_INTEG_GAIN = 3'd2;
   localparam logic [2:0] CSR_CPU        = 3'd3;
   localparam logic [2:0] CSR_PWM_MAX    = 3'd4;
   localparam logic [2:0] CSR_PWM_MIN    = 3'd5;
   localparam logic [2:0] CSR_STOP_MARG  = 3'd6;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/encoder_position_pid_move_unit.sv =====
// ---------------------------------------------------------------------------
// Encoder position PID move unit
// Position count, stop rule and clamped Q16.16 PID drive, one shared
// multiplier and one serial divider under a sequencer.
// ---------------------------------------------------------------------------
//   channel | ports               | direction
//   req     | req_valid/req_stall | in,  operation and operands
//   rsp     | rsp_valid/rsp_stall | out, drive result per tick
//   csr     | csr_write           | in,  register write
//
// Start and edge items finish in the idle state. A tick with non-zero
// elapsed time runs the 76-step serial divide of the rate term, a
// five-digit reciprocal divide for the integral and the shared
// multiplier for the gain terms; zero elapsed time skips the divide.
// A stop-rule tick goes from the check to the result, which waits while
// the output is stalled. Synchronous reset restores register defaults
// and state. A stalled result is held while the next item is taken in.
`include "encoder_position_pid_move_unit_assert.svh"

module encoder_position_pid_move_unit #(
   parameter int ELAPSED_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic signed [15:0]      req_target_units,
   input  logic                    req_enc_b_level,
   input  logic [ELAPSED_BITS-1:0] req_elapsed_us,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_motor_dir,
   output logic [7:0]              rsp_pwm_duty,
   output logic                    rsp_move_done,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_wdata
);
   import eppm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_INT_MUL, S_INT_LOAD, S_IDIV_MUL, S_IDIV_ACC, S_INT_UPD,
      S_DIFF_MUL, S_DER_DIV_GO, S_DER_DIV_WAIT, S_TERM_HI, S_TERM_LO, S_TERM_ACC,
      S_CLAMP, S_RESULT
   } state_type;

   localparam logic [31:0]          INT_DEN    = 32'd15625;
   // ceil(2^44 / 15625), exact for every 30-bit partial dividend
   localparam logic [MUL_W-1:0]     IDIV_RECIP = MUL_W'(1125899907);
   localparam logic [MUL_W-1:0]     US_PER_S   = MUL_W'(1000000);
   localparam logic [DIV_NUM_W-1:0] DERIV_LIM  = DIV_NUM_W'(1) << 46;
   localparam logic [63:0]          TERM_LIM   = 64'd1 << 61;
   localparam logic [63:0]          PH_LIM     = 64'd1 << 45;
   localparam logic signed [64:0]   INTEG_MAX  = 65'sh0_7FFF_FFFF_FFFF_FFFF;

   state_type state_ff;

   logic signed [31:0] prop_ff, deriv_ff, integ_ff;
   logic [15:0]        cpu_ff;
   logic [7:0]         pwm_max_ff, pwm_min_ff, margin_ff;

   logic signed [31:0] position_ff;
   logic signed [47:0] target_ff;
   logic signed [31:0] prev_err_ff;
   logic signed [63:0] integral_ff;

   logic [31:0]        elapsed_ff;
   logic signed [31:0] e_ff;
   logic signed [32:0] diff_ff;
   logic signed [47:0] dedt_ff;
   logic signed [63:0] u_ff;
   logic [63:0]        ph_ff;
   logic [1:0]         term_ff;

   logic [79:0]        idiv_num_ff;
   logic [13:0]        idiv_rem_ff;
   logic [63:0]        idiv_quo_ff;
   logic [2:0]         idiv_cnt_ff;

   logic [1:0] res_dir_ff;
   logic [7:0] res_duty_ff;
   logic       res_done_ff;

   logic       rsp_valid_ff;
   logic [1:0] rsp_dir_ff;
   logic [7:0] rsp_duty_ff;
   logic       rsp_done_ff;

   // shared units
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [2*MUL_W-1:0]   mul_p;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quo;
   div_status_type       div_stat;

   eppm_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   eppm_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quo    (div_quo),
      .status (div_stat)
   );

   // integral scaling: divide by 15625 one 16-bit digit at a time
   logic [31:0] idiv_x, idiv_r;
   logic [15:0] idiv_q;

   always_comb begin
      idiv_x = {2'b00, idiv_rem_ff, idiv_num_ff[79:64]};
      idiv_q = mul_p[59:44];
      idiv_r = idiv_x - (32'(idiv_q) * INT_DEN);
   end

   // stop rule and error
   logic signed [48:0] pos8, tgt49, approx, dpos, e_shift, e_in49;
   logic signed [31:0] e_in;
   logic               stop_hit;
   logic signed [32:0] targ_prod;

   always_comb begin
      pos8    = {{9{position_ff[31]}}, position_ff, 8'd0};
      tgt49   = {target_ff[47], target_ff};
      approx  = tgt49 - $signed({33'd0, margin_ff, 8'd0});
      stop_hit = ((pos8 >= approx) && (approx > 49'sd0)) ||
                 ((pos8 < approx) && (approx < 49'sd0));
      dpos    = pos8 - tgt49;
      e_shift = dpos >>> 8;
      e_in49  = e_shift + (((dpos < 49'sd0) && (dpos[7:0] != 8'd0)) ? 49'sd1 : 49'sd0);
      if (e_in49 > 49'sd2147483647) begin
         e_in = 32'sh7FFF_FFFF;
      end else if (e_in49 < -49'sd2147483648) begin
         e_in = 32'sh8000_0000;
      end else begin
         e_in = e_in49[31:0];
      end
      targ_prod = $signed({1'b0, cpu_ff}) * req_target_units;
   end

   // integral update
   logic signed [64:0] inc65, integral_sum;
   logic signed [63:0] integral_in;

   always_comb begin
      inc65 = $signed({2'b00, idiv_quo_ff[62:0]});
      if (e_ff < 32'sd0) begin
         inc65 = -inc65;
      end
      integral_sum = {integral_ff[63], integral_ff} + inc65;
      if (integral_sum > INTEG_MAX) begin
         integral_in = INTEG_MAX[63:0];
      end else if (integral_sum < -INTEG_MAX) begin
         integral_in = 64'(-INTEG_MAX);
      end else begin
         integral_in = integral_sum[63:0];
      end
   end

   // derivative
   logic [31:0]        diff_mag;
   logic [46:0]        dedt_mag;
   logic signed [47:0] dedt_in;

   always_comb begin
      diff_mag = diff_ff[32] ? 32'(-diff_ff) : diff_ff[31:0];
      dedt_mag = (div_quo > DERIV_LIM) ? DERIV_LIM[46:0] : div_quo[46:0];
      dedt_in  = diff_ff[32] ? -$signed({1'b0, dedt_mag}) : $signed({1'b0, dedt_mag});
   end

   // gain term operands
   logic signed [31:0] g_sel;
   logic signed [63:0] b_sel;
   logic [31:0]        g_mag;
   logic [63:0]        b_mag;
   logic               term_neg;
   logic [63:0]        r_raw, r_sat;
   logic signed [63:0] term_val;

   always_comb begin
      case (term_ff)
         2'd0: begin
            g_sel = prop_ff;
            b_sel = {{16{e_ff[31]}}, e_ff, 16'd0};
         end
         2'd1: begin
            g_sel = deriv_ff;
            b_sel = {dedt_ff, 16'd0};
         end
         default: begin
            g_sel = integ_ff;
            b_sel = integral_ff;
         end
      endcase
      g_mag    = g_sel[31] ? 32'(-g_sel) : g_sel;
      b_mag    = b_sel[63] ? 64'(-b_sel) : b_sel;
      term_neg = g_sel[31] ^ b_sel[63];
      r_raw    = (ph_ff >= PH_LIM) ? TERM_LIM : ((ph_ff << 16) + (mul_p >> 16));
      r_sat    = (r_raw > TERM_LIM) ? TERM_LIM : r_raw;
      term_val = term_neg ? -$signed(r_sat) : $signed(r_sat);
   end

   // output clamp
   logic [63:0] u_mag;
   logic [7:0]  duty_in;

   always_comb begin
      u_mag = u_ff[63] ? 64'(-u_ff) : u_ff;
      if (u_mag > {40'd0, pwm_max_ff, 16'd0}) begin
         duty_in = pwm_max_ff;
      end else if (u_mag < {40'd0, pwm_min_ff, 16'd0}) begin
         duty_in = pwm_min_ff;
      end else begin
         duty_in = u_mag[23:16];
      end
   end

   // shared unit operand selection
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      unique case (state_ff)
         S_INT_MUL: begin
            mul_a = e_ff[31] ? 32'(-e_ff) : e_ff;
            mul_b = elapsed_ff;
         end
         S_IDIV_MUL: begin
            mul_a = idiv_x;
            mul_b = IDIV_RECIP;
         end
         S_DIFF_MUL: begin
            mul_a = diff_mag;
            mul_b = US_PER_S;
         end
         S_DER_DIV_GO: begin
            div_start = elapsed_ff != 32'd0;
            div_num   = {12'd0, mul_p};
            div_den   = elapsed_ff;
         end
         S_TERM_HI: begin
            mul_a = g_mag;
            mul_b = b_mag[63:32];
         end
         S_TERM_LO: begin
            mul_a = g_mag;
            mul_b = b_mag[31:0];
         end
         default: ;
      endcase
   end

   logic req_take;
   logic rsp_free;

   assign req_take = req_valid && (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prop_ff      <= 32'sd65536;
         deriv_ff     <= 32'sd1638;
         integ_ff     <= 32'sd0;
         cpu_ff       <= 16'd1;
         pwm_max_ff   <= 8'd75;
         pwm_min_ff   <= 8'd30;
         margin_ff    <= 8'd5;
         position_ff  <= '0;
         target_ff    <= '0;
         prev_err_ff  <= '0;
         integral_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         term_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_PROP_GAIN:  prop_ff    <= csr_wdata;
               CSR_DERIV_GAIN: deriv_ff   <= csr_wdata;
               CSR_INTEG_GAIN: integ_ff   <= csr_wdata;
               CSR_CPU:        cpu_ff     <= csr_wdata[15:0];
               CSR_PWM_MAX:    pwm_max_ff <= csr_wdata[7:0];
               CSR_PWM_MIN:    pwm_min_ff <= csr_wdata[7:0];
               CSR_STOP_MARG:  margin_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  unique case (req_operation)
                     OP_START: begin
                        position_ff <= '0;
                        target_ff   <= 48'(targ_prod);
                     end
                     OP_EDGE: begin
                        if (req_enc_b_level) begin
                           if (position_ff != 32'sh7FFF_FFFF) begin
                              position_ff <= position_ff + 32'sd1;
                           end
                        end else if (position_ff != 32'sh8000_0000) begin
                           position_ff <= position_ff - 32'sd1;
                        end
                     end
                     OP_TICK: begin
                        elapsed_ff <= 32'(req_elapsed_us);
                        state_ff   <= S_CHECK;
                     end
                     default: ;
                  endcase
               end
            end
            S_CHECK: begin
               u_ff    <= '0;
               term_ff <= 2'd0;
               e_ff    <= e_in;
               diff_ff <= 33'(e_in) - 33'(prev_err_ff);
               if (stop_hit) begin
                  res_dir_ff  <= DIR_STOP;
                  res_duty_ff <= 8'd0;
                  res_done_ff <= 1'b1;
                  state_ff    <= S_RESULT;
               end else begin
                  state_ff <= S_INT_MUL;
               end
            end
            S_INT_MUL: state_ff <= S_INT_LOAD;
            S_INT_LOAD: begin
               // dividend is |e| * elapsed * 4096, five digits top first
               idiv_num_ff <= {4'd0, mul_p, 12'd0};
               idiv_rem_ff <= '0;
               idiv_quo_ff <= '0;
               idiv_cnt_ff <= 3'd4;
               state_ff    <= S_IDIV_MUL;
            end
            S_IDIV_MUL: state_ff <= S_IDIV_ACC;
            S_IDIV_ACC: begin
               idiv_rem_ff <= idiv_r[13:0];
               idiv_num_ff <= {idiv_num_ff[63:0], 16'd0};
               idiv_quo_ff <= {idiv_quo_ff[47:0], idiv_q};
               if (idiv_cnt_ff == 3'd0) begin
                  state_ff <= S_INT_UPD;
               end else begin
                  idiv_cnt_ff <= idiv_cnt_ff - 3'd1;
                  state_ff    <= S_IDIV_MUL;
               end
            end
            S_INT_UPD: begin
               integral_ff <= integral_in;
               state_ff    <= S_DIFF_MUL;
            end
            S_DIFF_MUL: state_ff <= S_DER_DIV_GO;
            S_DER_DIV_GO: begin
               if (elapsed_ff == 32'd0) begin
                  // no time passed: full-scale rate by the sign of the change
                  if (diff_ff > 33'sd0) begin
                     dedt_ff <= 48'sd70368744177664;
                  end else if (diff_ff < 33'sd0) begin
                     dedt_ff <= -48'sd70368744177664;
                  end else begin
                     dedt_ff <= '0;
                  end
                  state_ff <= S_TERM_HI;
               end else begin
                  state_ff <= S_DER_DIV_WAIT;
               end
            end
            S_DER_DIV_WAIT: begin
               if (div_stat.done) begin
                  dedt_ff  <= dedt_in;
                  state_ff <= S_TERM_HI;
               end
            end
            S_TERM_HI: state_ff <= S_TERM_LO;
            S_TERM_LO: begin
               ph_ff    <= mul_p;
               state_ff <= S_TERM_ACC;
            end
            S_TERM_ACC: begin
               u_ff <= u_ff + term_val;
               if (term_ff == 2'd2) begin
                  state_ff <= S_CLAMP;
               end else begin
                  term_ff  <= term_ff + 2'd1;
                  state_ff <= S_TERM_HI;
               end
            end
            S_CLAMP: begin
               res_dir_ff  <= u_ff[63] ? DIR_REV : DIR_FWD;
               res_duty_ff <= duty_in;
               res_done_ff <= 1'b0;
               prev_err_ff <= e_ff;
               state_ff    <= S_RESULT;
            end
            S_RESULT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dir_ff   <= res_dir_ff;
                  rsp_duty_ff  <= res_duty_ff;
                  rsp_done_ff  <= res_done_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_motor_dir = rsp_dir_ff;
   assign rsp_pwm_duty  = rsp_duty_ff;
   assign rsp_move_done = rsp_done_ff;

   `EPPM_ASSERT(a_done_stops, clock, reset,
      rsp_valid_ff && rsp_done_ff |-> rsp_dir_ff == DIR_STOP && rsp_duty_ff == 8'd0,
      "stop result drives motor")
   `EPPM_ASSERT(a_drive_dir, clock, reset,
      rsp_valid_ff && !rsp_done_ff |-> rsp_dir_ff != DIR_STOP,
      "drive result without direction")
   `EPPM_ASSERT(a_div_idle, clock, reset,
      div_start |-> !div_stat.busy, "divider restarted while busy")
   `EPPM_ASSERT_NORST(a_reset_empty, clock,
      reset |=> !rsp_valid_ff && state_ff == S_IDLE, "reset left work pending")

endmodule

// ===== rtl/eppm_divider.sv =====
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient, one bit per cycle.
// ---------------------------------------------------------------------------
module eppm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [eppm_pkg::DIV_NUM_W-1:0] num,
   input  logic [eppm_pkg::DIV_DEN_W-1:0] den,
   output logic [eppm_pkg::DIV_NUM_W-1:0] quo,
   output eppm_pkg::div_status_type       status
);
   import eppm_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            cnt_ff  <= CNT_W'(DIV_NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= DIV_DEN_W'(trial - {1'b0, den_ff});
            end else begin
               rem_ff <= trial[DIV_DEN_W-1:0];
            end
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quo         = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/eppm_mult.sv =====
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 product, registered.
// ---------------------------------------------------------------------------
module eppm_mult (
   input  logic                         clock,
   input  logic [eppm_pkg::MUL_W-1:0]   op_a,
   input  logic [eppm_pkg::MUL_W-1:0]   op_b,
   output logic [2*eppm_pkg::MUL_W-1:0] prod
);
   import eppm_pkg::*;

   logic [2*MUL_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule
